>>> sv/hwp_pkg.sv
package hwp_pkg;

	localparam int unsigned POS_BITS_DEF = 16;
	localparam int unsigned RQ_DEPTH     = 4;
	localparam int unsigned RQ_AW        = $clog2(RQ_DEPTH);

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_DEL    = 8'h7F;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_TOKEN,
		PH_QUOTED,
		PH_IDLE
	} phase_t;

	typedef enum logic [2:0] {
		FS_NONE,
		FS_RUN,
		FS_CR,
		FS_CRLF,
		FS_RUN_CR,
		FS_RUN_CRLF
	} fold_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       frame_end;
	} chr_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  result_kind;
		logic        was_token;
		logic [15:0] end_position;
		logic        run_last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       first;
		res_t       second;
	} res_pair_t;

	function automatic logic tok_char(input logic [7:0] c);
		logic ok;
		ok = (c > 8'h20) && (c < 8'h7F);
		case (c)
			8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
			8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D: ok = 1'b0;
			default: ;
		endcase
		return ok;
	endfunction

	function automatic logic lead_space(input logic [7:0] c);
		return (c == CH_SP) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

endpackage

>>> sv/http_word_parser_core.sv
// channel | valid    | stall    | payload          | moves
// input   | chr_valid| chr_stall| chr (chr_t)      | one raw byte and frame end flag
// result  | res_valid| res_stall| res (res_t)      | one content, done or error item
//
// one byte enters per cycle unless the input stalls; a byte that gives two result
// items (frame end closing a word) leaves one extra item in the four-entry result
// queue, and the input stalls when a second such byte comes before it drains
// a byte is held in the input register and its results then in the result queue
// arst_n clears the parser state, the input register's valid flag and the queue
// a stalled result port fills the queue and then stalls the input
module http_word_parser_core #(
	parameter int unsigned POSITION_BITS = hwp_pkg::POS_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          chr_valid,
	output logic          chr_stall,
	input  hwp_pkg::chr_t chr,
	output logic          res_valid,
	input  logic          res_stall,
	output hwp_pkg::res_t res
);
	import hwp_pkg::*;

	chr_t                     chr_s1;
	logic                     vld_s1;
	phase_t                   phase_q;
	fold_t                    fold_q;
	logic                     esc_q;
	logic [POSITION_BITS-1:0] pos_q;
	phase_t                   phase_nxt;
	fold_t                    fold_nxt;
	logic                     esc_nxt;
	logic [POSITION_BITS-1:0] pos_nxt;
	res_pair_t                pair;
	logic                     room;
	logic                     adv;

	assign adv       = vld_s1 && room;
	assign chr_stall = vld_s1 && !room;

	always_ff @(posedge clk) begin
		if (!chr_stall && chr_valid) begin
			chr_s1 <= chr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			phase_q <= PH_SKIP;
			fold_q  <= FS_NONE;
			esc_q   <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (!chr_stall) begin
				vld_s1 <= chr_valid;
			end
			if (adv) begin
				phase_q <= phase_nxt;
				fold_q  <= fold_nxt;
				esc_q   <= esc_nxt;
				pos_q   <= pos_nxt;
			end
		end
	end

	hwp_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.chr      (chr_s1),
		.phase    (phase_q),
		.fold     (fold_q),
		.esc      (esc_q),
		.pos      (pos_q),
		.phase_nxt(phase_nxt),
		.fold_nxt (fold_nxt),
		.esc_nxt  (esc_nxt),
		.pos_nxt  (pos_nxt),
		.pair     (pair)
	);

	hwp_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (adv),
		.pair     (pair),
		.room     (room),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

>>> sv/hwp_step.sv
module hwp_step #(
	parameter int unsigned POSITION_BITS = hwp_pkg::POS_BITS_DEF
) (
	input  hwp_pkg::chr_t            chr,
	input  hwp_pkg::phase_t          phase,
	input  hwp_pkg::fold_t           fold,
	input  logic                     esc,
	input  logic [POSITION_BITS-1:0] pos,
	output hwp_pkg::phase_t          phase_nxt,
	output hwp_pkg::fold_t           fold_nxt,
	output logic                     esc_nxt,
	output logic [POSITION_BITS-1:0] pos_nxt,
	output hwp_pkg::res_pair_t       pair
);
	import hwp_pkg::*;

	logic [7:0]               c;
	logic [POSITION_BITS-1:0] pos_after;
	logic [31:0]              pos_b32;
	logic [31:0]              pos_a32;
	logic                     m_vld;
	logic                     f_vld;
	res_t                     m;
	res_t                     f;

	assign c         = chr.in_byte;
	assign pos_after = (pos == '1) ? pos : pos + POSITION_BITS'(1);
	assign pos_b32   = 32'(pos);
	assign pos_a32   = 32'(pos_after);

	always_comb begin
		m_vld     = 1'b0;
		m         = '0;
		phase_nxt = phase;
		fold_nxt  = fold;
		esc_nxt   = esc;
		case (phase)
			PH_SKIP: begin
				if (lead_space(c)) begin
				end else if (c == CH_QUOTE) begin
					phase_nxt = PH_QUOTED;
					fold_nxt  = FS_NONE;
					esc_nxt   = 1'b0;
				end else if (tok_char(c)) begin
					m_vld      = 1'b1;
					m.out_byte = c;
					phase_nxt  = PH_TOKEN;
				end else begin
					m_vld         = 1'b1;
					m.result_kind = KIND_ERROR;
					phase_nxt     = PH_IDLE;
				end
			end
			PH_TOKEN: begin
				m_vld = 1'b1;
				if (tok_char(c)) begin
					m.out_byte = c;
				end else begin
					m.result_kind  = KIND_DONE;
					m.was_token    = 1'b1;
					m.end_position = pos_b32[15:0];
					phase_nxt      = PH_IDLE;
				end
			end
			PH_QUOTED: begin
				if (fold == FS_CR || fold == FS_RUN_CR) begin
					if (c == CH_LF) begin
						fold_nxt = (fold == FS_CR) ? FS_CRLF : FS_RUN_CRLF;
					end else begin
						m_vld         = 1'b1;
						m.result_kind = KIND_ERROR;
						phase_nxt     = PH_IDLE;
					end
				end else if (fold == FS_CRLF || fold == FS_RUN_CRLF) begin
					if (c == CH_SP || c == CH_HT) begin
						m_vld      = (fold == FS_CRLF);
						m.out_byte = (fold == FS_CRLF) ? CH_SP : 8'h00;
						esc_nxt    = 1'b0;
						fold_nxt   = FS_RUN;
					end else begin
						m_vld         = 1'b1;
						m.result_kind = KIND_ERROR;
						phase_nxt     = PH_IDLE;
					end
				end else if (c == CH_SP || c == CH_HT) begin
					if (fold == FS_NONE) begin
						m_vld      = 1'b1;
						m.out_byte = CH_SP;
						esc_nxt    = 1'b0;
						fold_nxt   = FS_RUN;
					end
				end else if (c == CH_CR) begin
					fold_nxt = (fold == FS_RUN) ? FS_RUN_CR : FS_CR;
				end else begin
					fold_nxt = FS_NONE;
					if (c < 8'h20 || c == CH_DEL) begin
						m_vld         = 1'b1;
						m.result_kind = KIND_ERROR;
						phase_nxt     = PH_IDLE;
					end else if (esc) begin
						m_vld      = 1'b1;
						m.out_byte = c;
						esc_nxt    = 1'b0;
					end else if (c == CH_BSLASH) begin
						esc_nxt = 1'b1;
					end else if (c == CH_QUOTE) begin
						m_vld          = 1'b1;
						m.result_kind  = KIND_DONE;
						m.end_position = pos_a32[15:0];
						phase_nxt      = PH_IDLE;
					end else begin
						m_vld      = 1'b1;
						m.out_byte = c;
					end
				end
			end
			default: ;
		endcase

		// end of frame closes the word and clears the state
		f_vld   = 1'b0;
		f       = '0;
		pos_nxt = pos_after;
		if (chr.frame_end) begin
			if (phase_nxt == PH_TOKEN) begin
				f_vld          = 1'b1;
				f.result_kind  = KIND_DONE;
				f.was_token    = 1'b1;
				f.end_position = pos_a32[15:0];
			end else if (phase_nxt == PH_SKIP || phase_nxt == PH_QUOTED) begin
				f_vld         = 1'b1;
				f.result_kind = KIND_ERROR;
			end
			phase_nxt = PH_SKIP;
			fold_nxt  = FS_NONE;
			esc_nxt   = 1'b0;
			pos_nxt   = '0;
		end

		pair = '0;
		if (m_vld && f_vld) begin
			pair.cnt             = 2'd2;
			pair.first           = m;
			pair.second          = f;
			pair.second.run_last = 1'b1;
		end else if (m_vld || f_vld) begin
			pair.cnt            = 2'd1;
			pair.first          = m_vld ? m : f;
			pair.first.run_last = 1'b1;
		end
	end

endmodule

>>> sv/hwp_resq.sv
module hwp_resq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_en,
	input  hwp_pkg::res_pair_t  pair,
	output logic                room,
	output logic                res_valid,
	input  logic                res_stall,
	output hwp_pkg::res_t       res
);
	import hwp_pkg::*;

	res_t             ent_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wp_q;
	logic [RQ_AW-1:0] rp_q;
	logic [RQ_AW:0]   cnt_q;
	logic             pop;
	logic [1:0]       n_push;
	logic [RQ_AW-1:0] wp_1;

	assign pop       = res_valid && !res_stall;
	assign n_push    = push_en ? pair.cnt : 2'd0;
	assign wp_1      = wp_q + RQ_AW'(1);
	assign room      = (cnt_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign res_valid = (cnt_q != '0);
	assign res       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			ent_q[wp_q] <= pair.first;
		end
		if (n_push == 2'd2) begin
			ent_q[wp_1] <= pair.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + RQ_AW'(n_push);
			rp_q  <= rp_q + RQ_AW'(pop);
			cnt_q <= cnt_q + (RQ_AW+1)'(n_push) - (RQ_AW+1)'(pop);
		end
	end

endmodule

>>> sv/hwp_checker.sv
module hwp_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          chr_valid,
	input logic          chr_stall,
	input hwp_pkg::chr_t chr,
	input logic          res_valid,
	input logic          res_stall,
	input hwp_pkg::res_t res
);
	import hwp_pkg::*;

	// a held result item does not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.result_kind == KIND_BYTE || res.result_kind == KIND_DONE
			|| res.result_kind == KIND_ERROR))
		else $error("undefined result kind");

	// done and error close everything a byte causes
	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind != KIND_BYTE |-> res.run_last && res.out_byte == 8'h00)
		else $error("closing item not last or carries a byte");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.result_kind != KIND_DONE
			|-> !res.was_token && res.end_position == 16'h0000)
		else $error("finish fields set on non-finish item");

endmodule

bind http_word_parser_core hwp_checker u_chk (.*);
